// ===== src/saq_pkg.sv =====
// Package with the shared types and constants of the sorted-array priority queue.
package saq_pkg;

  // Number of cells in the chain and the width of the key count.
  localparam int unsigned CAPACITY = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELMAX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  // Status codes returned with every result.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One operation request.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    key_t              key;
  } saq_req_t;

  // One result.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    key_t                removed_key;
    logic                found;
    cnt_t                count;
  } saq_rsp_t;

  // What a cell hands to its upper neighbor: its key and whether it sorts below the request key.
  typedef struct packed {
    logic lt;
    key_t key;
  } saq_link_t;

endpackage

// ===== src/saq_cell.sv =====
// One storage cell of the sorted chain: holds a key and shifts up on insert.
module saq_cell
  import saq_pkg::*;
(
  input  logic      clk_i,
  input  logic      insert_i,
  input  key_t      key_i,
  input  logic      valid_i,
  input  saq_link_t left_i,
  output saq_link_t link_o,
  output logic      match_o,
  output key_t      key_o
);

  key_t key_q;
  key_t key_d;

  // Compare the stored key against the request key.
  assign link_o.lt  = valid_i && (key_q < key_i);
  assign link_o.key = key_q;
  assign match_o    = valid_i && (key_q == key_i);
  assign key_o      = key_q;

  // A cell below the insertion point keeps its key; the cell at the point takes the
  // new key, and every cell above it takes its lower neighbor's key.
  always_comb begin
    key_d = key_q;
    if (insert_i && !link_o.lt) begin
      key_d = left_i.lt ? key_i : left_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

// ===== src/sorted_array_priority_queue.sv =====
// Top level of the sorted-array max priority queue built from a chain of key cells.
//
// The queue holds up to CAPACITY keys in ascending order, one per cell. Each request
// is first registered; when it executes, every cell compares its key with the request
// key at once and, on insert, shifts toward the top in parallel. A new request is
// accepted only once the pending one has executed, so the queue takes one request at a
// time; the pending request waits while the previous result is still stalled in the
// output register. No clearing pass is needed after reset: only cells below the count
// are ever read.
module sorted_array_priority_queue
  import saq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  saq_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output saq_rsp_t out_rsp_o
);

  logic      op_valid_q, op_valid_d;
  saq_req_t  req_q;
  logic      out_valid_q, out_valid_d;
  saq_rsp_t  rsp_q, rsp_d;
  cnt_t      count_q, count_d;
  logic      accept;
  logic      exec;
  logic      do_insert;
  logic      [CAPACITY-1:0] cell_valid;
  logic      [CAPACITY-1:0] cell_top;
  logic      [CAPACITY-1:0] cell_match;
  key_t      cell_key [CAPACITY];
  saq_link_t link [CAPACITY+1];
  key_t      top_key;
  logic      any_match;

  // Handshake: one request in flight, executed when the output register can take it.
  assign in_stall_o = op_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign exec       = op_valid_q && (!out_valid_q || !out_stall_i);
  assign do_insert  = exec && (req_q.kind == KIND_INSERT) && (count_q < cnt_t'(CAPACITY));

  // The virtual cell below the bottom sorts below any key.
  assign link[0].lt  = 1'b1;
  assign link[0].key = '0;

  // Chain of cells; validity and the top position follow from the count.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_valid[i] = cnt_t'(i) < count_q;
    assign cell_top[i]   = cnt_t'(i + 1) == count_q;

    saq_cell u_cell (
      .clk_i    (clk_i),
      .insert_i (do_insert),
      .key_i    (req_q.key),
      .valid_i  (cell_valid[i]),
      .left_i   (link[i]),
      .link_o   (link[i+1]),
      .match_o  (cell_match[i]),
      .key_o    (cell_key[i])
    );
  end

  // Select the top key and reduce the match flags across the chain.
  always_comb begin
    top_key = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      top_key = top_key | (cell_key[i] & {KEY_W{cell_top[i]}});
    end
  end
  assign any_match = |cell_match;

  // Result and count update for the executing request.
  always_comb begin
    count_d           = count_q;
    rsp_d             = rsp_q;
    if (exec) begin
      rsp_d.status      = ST_DONE;
      rsp_d.removed_key = '0;
      rsp_d.found       = 1'b0;
      unique case (req_q.kind)
        KIND_INSERT: begin
          if (count_q < cnt_t'(CAPACITY)) begin
            count_d = count_q + cnt_t'(1);
          end else begin
            rsp_d.status = ST_FULL;
          end
        end
        KIND_DELMAX: begin
          if (count_q == '0) begin
            rsp_d.status = ST_EMPTY;
          end else begin
            count_d           = count_q - cnt_t'(1);
            rsp_d.removed_key = top_key;
          end
        end
        KIND_LOOKUP: begin
          rsp_d.found = any_match;
        end
        default: begin
        end
      endcase
      rsp_d.count = count_d;
    end
  end

  // Request register and output register control.
  always_comb begin
    op_valid_d = op_valid_q;
    if (accept) begin
      op_valid_d = 1'b1;
    end else if (exec) begin
      op_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (exec) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      op_valid_q  <= op_valid_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // The count never exceeds the number of cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(CAPACITY))
    else $error("key count above capacity");

  // Every executed request leaves a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> out_valid_q)
    else $error("executed request produced no result");

  // One request moves the count by at most one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + cnt_t'(1))
             || (count_q == $past(count_q) - cnt_t'(1)))
    else $error("count moved by more than one");

  // A full rejection is reported only when every cell is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (rsp_q.status == ST_FULL)) |-> (rsp_q.count == cnt_t'(CAPACITY)))
    else $error("full status with free cells");

  // The count changes only when a request executes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec |=> $stable(count_q))
    else $error("count changed without a request");

endmodule
